// ----- rtl/core/mbps_pkg.sv -----
// Shared types and constants for the masked byte pattern scan unit.
`default_nettype none

package mbps_pkg;

  // Window depth, which is also the longest pattern in bytes.
  localparam int unsigned PatBytes = 16;
  localparam int unsigned LenW     = $clog2(PatBytes + 1);
  localparam int unsigned WinW     = 8 * PatBytes;

  // Fixed register and field widths.
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned AddrW    = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 3'd0,
    CfgPatternHigh = 3'd1,
    CfgCareMask    = 3'd2,
    CfgPatternLen  = 3'd3,
    CfgOccurrence  = 3'd4,
    CfgBaseAddr    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0]      pattern_low;
    logic [63:0]      pattern_high;
    logic [15:0]      care_mask;
    logic [4:0]       pattern_length;
    logic [31:0]      occurrence_index;
    logic [AddrW-1:0] base_address;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } out_item_t;

  // What the front end hands to the back end for every accepted byte.
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [AddrW-1:0] start;
  } scan_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/mbps_front.sv -----
// Front end: byte window, byte count and masked window compare.
`default_nettype none

module mbps_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbps_pkg::cfg_t        cfg_i,
  input  logic                  accept_i,
  input  mbps_pkg::in_item_t    item_i,
  output mbps_pkg::scan_entry_t entry_o
);
  import mbps_pkg::*;

  logic [WinW-1:0]  win_q, win_d, win_new;
  logic [31:0]      bytes_q, bytes_d, bytes_new;
  logic [WinW-1:0]  pat_vec, pat_rev, pat_exp;
  logic [PatBytes-1:0] care_rev, care_exp, byte_ok;
  logic [127:0]     pat_full;
  logic [LenW-1:0]  len_eff, len_gap, len_m1;
  logic             len_ok;

  assign pat_full = {cfg_i.pattern_high, cfg_i.pattern_low};
  assign pat_vec  = pat_full[WinW-1:0];

  assign len_eff = (cfg_i.pattern_length > LenW'(PatBytes)) ? LenW'(PatBytes)
                                                            : cfg_i.pattern_length[LenW-1:0];
  assign len_gap = LenW'(PatBytes) - len_eff;
  assign len_m1  = (len_eff == '0) ? '0 : len_eff - LenW'(1);

  // Pattern byte i lines up with window entry len-1-i: reverse, then shift right.
  always_comb begin
    for (int k = 0; k < PatBytes; k++) begin
      pat_rev[8*k +: 8] = pat_vec[8*(PatBytes-1-k) +: 8];
      care_rev[k]       = cfg_i.care_mask[PatBytes-1-k];
    end
  end

  assign pat_exp  = pat_rev >> {len_gap, 3'b000};
  assign care_exp = care_rev >> len_gap;

  assign win_new   = {win_q[WinW-9:0], item_i.data_byte};
  assign bytes_new = bytes_q + 32'd1;

  always_comb begin
    for (int k = 0; k < PatBytes; k++) begin
      byte_ok[k] = !care_exp[k] || (win_new[8*k +: 8] == pat_exp[8*k +: 8]);
    end
  end

  assign len_ok = (len_eff == '0) || (bytes_new >= 32'(len_eff));

  assign entry_o.hit   = len_ok && (&byte_ok);
  assign entry_o.last  = item_i.last_byte;
  assign entry_o.start = bytes_q - 32'(len_m1);

  always_comb begin
    win_d   = win_q;
    bytes_d = bytes_q;
    if (accept_i) begin
      if (item_i.last_byte) begin
        win_d   = '0;
        bytes_d = '0;
      end else begin
        win_d   = win_new;
        bytes_d = bytes_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      bytes_q <= '0;
    end else begin
      win_q   <= win_d;
      bytes_q <= bytes_d;
    end
  end

  // A region's last byte leaves the window and count clear for the next one.
  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && item_i.last_byte) |=> (bytes_q == '0 && win_q == '0))
    else $error("front state not cleared after last byte");

endmodule

`default_nettype wire

// ----- rtl/core/mbps_queue.sv -----
// Two-entry queue between front and back end.
`default_nettype none

module mbps_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  mbps_pkg::scan_entry_t push_entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output mbps_pkg::scan_entry_t entry_o
);
  import mbps_pkg::*;

  scan_entry_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'd2)
    else $error("queue count beyond depth");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ----- rtl/core/mbps_back.sv -----
// Back end: match counting, report decision and output register.
`default_nettype none

module mbps_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mbps_pkg::cfg_t        cfg_i,
  input  logic                  q_valid_i,
  input  mbps_pkg::scan_entry_t q_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mbps_pkg::out_item_t   out_item_o
);
  import mbps_pkg::*;

  logic        done_q, done_d;
  logic [31:0] matches_q, matches_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q, out_item_d;
  logic        emit;

  assign pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    done_d      = done_q;
    matches_d   = matches_q;
    emit        = 1'b0;
    out_item_d  = out_item_q;
    if (pop_o) begin
      if (!done_q) begin
        if (q_entry_i.hit) begin
          if (matches_q == cfg_i.occurrence_index) begin
            emit                     = 1'b1;
            done_d                   = 1'b1;
            out_item_d.found         = 1'b1;
            out_item_d.match_address = cfg_i.base_address + q_entry_i.start;
          end else begin
            matches_d = matches_q + 32'd1;
          end
        end
        if (q_entry_i.last && !emit) begin
          emit                     = 1'b1;
          out_item_d.found         = 1'b0;
          out_item_d.match_address = '0;
        end
      end
      if (q_entry_i.last) begin
        done_d    = 1'b0;
        matches_d = '0;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= 1'b0;
      matches_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      matches_q   <= matches_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !(pop_o && q_entry_i.last)) |=> done_q)
    else $error("search done dropped before end of region");

  a_region_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_entry_i.last) |=> (!done_q && matches_q == '0))
    else $error("match state not cleared after last byte");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.found) |-> (out_item_o.match_address == '0))
    else $error("not-found item carries an address");

endmodule

`default_nettype wire

// ----- rtl/core/masked_byte_pattern_scan_unit.sv -----
// Top level of the masked byte pattern scan unit: config registers and wiring.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_item_i (data_byte, last_byte)
//  out     | output    | out_valid_o / out_stall_i | out_item_o (found, match_address)
//  cfg     | input     | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// Throughput is one item per cycle while in_stall_o is low; the window compare in
// the front end is a combinational parallel match over all pattern bytes.
// Each accepted byte's entry is written into the queue; the back end pops it, and
// loads any result into the output register, once that register is free or taken.
// Reset clears the window, counters and queue at once; no clearing pass.
// Output stalls back up through the two-entry queue; in_stall_o rises only
// when the queue is full.
`default_nettype none

module masked_byte_pattern_scan_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // byte stream
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mbps_pkg::in_item_t            in_item_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mbps_pkg::out_item_t           out_item_o,
  // config writes
  input  logic                          cfg_we_i,
  input  logic [mbps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mbps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import mbps_pkg::*;

  cfg_t        cfg_q, cfg_d;
  scan_entry_t front_entry, q_entry;
  logic        q_full, q_valid, q_pop, in_accept;

  // Config register file. Unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgPatternLow:  cfg_d.pattern_low      = cfg_wdata_i;
        CfgPatternHigh: cfg_d.pattern_high     = cfg_wdata_i;
        CfgCareMask:    cfg_d.care_mask        = cfg_wdata_i[15:0];
        CfgPatternLen:  cfg_d.pattern_length   = cfg_wdata_i[4:0];
        CfgOccurrence:  cfg_d.occurrence_index = cfg_wdata_i[31:0];
        CfgBaseAddr:    cfg_d.base_address     = cfg_wdata_i[AddrW-1:0];
        default:        cfg_d                  = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low      <= '0;
      cfg_q.pattern_high     <= '0;
      cfg_q.care_mask        <= 16'hFFFF;
      cfg_q.pattern_length   <= 5'd1;
      cfg_q.occurrence_index <= '0;
      cfg_q.base_address     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end takes a byte whenever the queue has room.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  mbps_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (in_accept),
    .item_i   (in_item_i),
    .entry_o  (front_entry)
  );

  mbps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_accept),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .entry_o      (q_entry)
  );

  // Back end counts matches, decides the report and holds the result item.
  mbps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
